>>> rtl/frustum_point_set_cull_assert.svh
// Assertion macros for the frustum point set cull RTL.
// Each macro expands to one labeled concurrent assertion on a clock and active-low reset.
`ifndef FRUSTUM_POINT_SET_CULL_ASSERT_SVH
`define FRUSTUM_POINT_SET_CULL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpsc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpsc assertion failed");

`endif

>>> rtl/fpsc_pkg.sv
// Package for the frustum point set cull block: widths, plane packing and register indexes.
// No dependencies; the interface, plane test and top-level files refer to it by scoped names.
package fpsc_pkg;

  localparam int COORD_BITS = 16;
  localparam int NUM_PLANES = 6;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;

  // Plane word packing: three Q1.14 normal components, then a Q8.8 offset.
  localparam int NORM_W     = 16;
  localparam int OFS_W      = 16;
  localparam int FRAC_SHIFT = 14;

  localparam int PROD_W  = NORM_W + COORD_BITS;
  localparam int OFS_T_W = OFS_W + FRAC_SHIFT;
  localparam int BASE_W  = (PROD_W > OFS_T_W) ? PROD_W : OFS_T_W;
  // Three products plus the offset term, with sign headroom.
  localparam int SUM_W   = BASE_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_3 = 3'd5;

  localparam logic [NUM_PLANES-1:0] ALL_PLANES = '1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

endpackage

>>> rtl/fpsc_chan_if.sv
// Valid/ready channel interfaces for the point stream and the visibility result.
// Depends on fpsc_pkg for the coordinate width.
interface fpsc_point_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [fpsc_pkg::COORD_BITS-1:0] point_x;
  logic signed [fpsc_pkg::COORD_BITS-1:0] point_y;
  logic signed [fpsc_pkg::COORD_BITS-1:0] point_z;
  logic                                   last_point;

  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface fpsc_result_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

>>> rtl/fpsc_plane_test.sv
// One plane test: registered normal-by-coordinate products, then the exact sum and sign check.
// Depends on fpsc_pkg for widths and the point type.
module fpsc_plane_test (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [fpsc_pkg::CFG_W-1:0]    plane,
  input  fpsc_pkg::point_t              pt,
  input  logic                          allow_zero,
  output logic                          in_half
);

  localparam int PW = fpsc_pkg::PROD_W;
  localparam int SW = fpsc_pkg::SUM_W;
  localparam int NW = fpsc_pkg::NORM_W;
  localparam int OW = fpsc_pkg::OFS_W;

  logic signed [NW-1:0] nx, ny, nz;
  logic signed [OW-1:0] d;

  logic signed [PW-1:0] prod_x_r, prod_y_r, prod_z_r;
  logic signed [OW-1:0] ofs_r;

  logic signed [fpsc_pkg::OFS_T_W-1:0] ofs_term;
  logic signed [SW-1:0]                sum;

  assign nx = plane[NW-1:0];
  assign ny = plane[2*NW-1:NW];
  assign nz = plane[3*NW-1:2*NW];
  assign d  = plane[3*NW+OW-1:3*NW];

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_x_r <= PW'(nx * pt.x);
      prod_y_r <= PW'(ny * pt.y);
      prod_z_r <= PW'(nz * pt.z);
      ofs_r    <= d;
    end
  end

  // The Q8.8 offset is aligned to the Q9.22 product scale.
  assign ofs_term = {ofs_r, {fpsc_pkg::FRAC_SHIFT{1'b0}}};
  assign sum = SW'(prod_x_r) + SW'(prod_y_r) + SW'(prod_z_r) + SW'(ofs_term);

  assign in_half = allow_zero ? !sum[SW-1] : (!sum[SW-1] && (sum != '0));

endmodule

>>> rtl/frustum_point_set_cull.sv
// Frustum point set cull: a three-register pipeline (input, products, result).
// The result for a set is registered after the set's last point passes the input and product registers.
// Throughput: one point per cycle while the output is not stalled; the result handshake sets the pace.
// Output stalls hold the whole pipeline; sets that end without a stall never slow intake.
// Reset (synchronous, rst_n low) clears the planes, the per-plane record and all valid flags.
`include "frustum_point_set_cull_assert.svh"

module frustum_point_set_cull (
  input  logic                                 clk,
  input  logic                                 rst_n,
  fpsc_point_if.sink                           in_chan,
  fpsc_result_if.source                        out_chan,
  input  logic                                 cfg_we,
  input  logic [fpsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fpsc_pkg::CFG_W-1:0]           cfg_data
);

  localparam int NP = fpsc_pkg::NUM_PLANES;

  logic [fpsc_pkg::CFG_W-1:0] plane_r [NP];

  logic             adv;
  logic             s1_valid_r, s1_last_r;
  fpsc_pkg::point_t s1_pt_r;
  logic             s2_valid_r, s2_last_r;
  logic [NP-1:0]    plane_hit;
  logic [NP-1:0]    seen_r, seen_nxt;
  logic             out_valid_r, out_visible_r;
  logic             set_end;

  // The pipeline moves whenever the result register is empty or being taken.
  assign adv = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NP; i++) begin
        plane_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index <= fpsc_pkg::REG_SIDE_3)) begin
      plane_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pt_r.x <= in_chan.point_x;
      s1_pt_r.y <= in_chan.point_y;
      s1_pt_r.z <= in_chan.point_z;
      s1_last_r <= in_chan.last_point;
      s2_last_r <= s1_last_r;
    end
  end

  for (genvar p = 0; p < NP; p++) begin : g_plane
    fpsc_plane_test u_test (
      .clk        (clk),
      .adv        (adv),
      .plane      (plane_r[p]),
      .pt         (s1_pt_r),
      .allow_zero (fpsc_pkg::CFG_IDX_W'(p) == fpsc_pkg::REG_FAR),
      .in_half    (plane_hit[p])
    );
  end

  assign seen_nxt = seen_r | plane_hit;
  assign set_end  = adv && s2_valid_r && s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_chan.valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r && s2_last_r;
      if (s2_valid_r) begin
        seen_r <= s2_last_r ? '0 : seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r && s2_last_r) begin
      out_visible_r <= (seen_nxt == fpsc_pkg::ALL_PLANES);
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.visible = out_visible_r;

  `FPSC_ASSERT_NEXT(a_last_makes_word, clk, rst_n, set_end, out_valid_r)
  `FPSC_ASSERT_NEXT(a_last_clears_seen, clk, rst_n, set_end, seen_r == '0)
  `FPSC_ASSERT_NEXT(a_stall_holds, clk, rst_n, !adv, $stable(s2_valid_r) && $stable(seen_r))
  `FPSC_ASSERT_NEXT(a_full_set_visible, clk, rst_n, set_end && (seen_nxt == '1), out_visible_r)
  `FPSC_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid_r, in_chan.ready)

endmodule
